FILE: sv/dba_pkg.sv
// Package with the shared constants and command codes of the dual bitmap allocator.
`default_nettype none

package dba_pkg;

  // Bytes in each allocation map.
  localparam int MAP_BYTES = 512;
  localparam int MAP_BITS  = MAP_BYTES * 8;
  // Result indexes are 12 bits wide, so a find never looks beyond bit 4095.
  localparam int INDEX_LIMIT = 4096;
  localparam int SCAN_BITS   = (MAP_BITS < INDEX_LIMIT) ? MAP_BITS : INDEX_LIMIT;

  // Each memory word holds 64 consecutive bits of one map.
  localparam int ROW_BITS  = 64;
  localparam int POS_W     = 6;
  localparam int ROWS      = (MAP_BITS + ROW_BITS - 1) / ROW_BITS;
  localparam int ROW_AW    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int SCAN_ROWS = (SCAN_BITS + ROW_BITS - 1) / ROW_BITS;
  localparam int LAST_CNT  = SCAN_BITS - (SCAN_ROWS - 1) * ROW_BITS;
  localparam logic [ROW_BITS-1:0] LAST_MASK = (LAST_CNT == ROW_BITS) ? '1 :
      ((ROW_BITS'(1) << LAST_CNT) - ROW_BITS'(1));

  localparam int CMD_W     = 2;
  localparam int IDX_W     = 12;

  localparam logic [CMD_W-1:0] CMD_SET   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FIND  = 2'd2;

endpackage

`default_nettype wire

FILE: sv/dual_bitmap_allocator.sv
// Top level of the dual bitmap allocator: two bit maps in one word memory with set, clear and find.
`default_nettype none

// A command is taken when start is high and busy is low; its one result is shown on
// free_index and found for the single cycle in which done is high, and it cannot be held off.
// Both maps sit in one memory of 64-bit words, one row of 64 bits per read, with a valid bit
// per row so that the maps read as all zeros after reset without any clearing pass.
// A set or clear is a read-modify-write of one row: the row is read in S_RMW_RD and written
// back in S_RMW_WR, which raises done. A find reads one row per cycle until it sees a zero
// or has checked the last of its 64 rows, bound by the single memory read port.
// An unused command, or a set or clear past the end of the map, shows its result in the
// cycle after it is taken and never raises busy. For the other commands busy stays high
// from the cycle after the command is taken until its result is shown.
module dual_bitmap_allocator (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic [dba_pkg::CMD_W-1:0] command,
  input  wire logic                      map_select,
  input  wire logic [dba_pkg::IDX_W-1:0] bit_index,
  output logic                           done,
  output logic      [dba_pkg::IDX_W-1:0] free_index,
  output logic                           found
);
  import dba_pkg::*;

  localparam int MEM_AW    = ROW_AW + 1;
  localparam int MEM_DEPTH = 1 << MEM_AW;
  localparam logic [ROW_AW-1:0] LAST_ROW = ROW_AW'(SCAN_ROWS - 1);

  typedef enum logic [1:0] {S_IDLE, S_RMW_RD, S_RMW_WR, S_SCAN} state_t;

  state_t                state;
  logic                  op_set;
  logic                  op_map;
  logic [ROW_AW-1:0]     op_row;
  logic [POS_W-1:0]      op_pos;
  logic [ROW_AW-1:0]     iss_row;
  logic                  issuing;
  logic                  chk_vld;
  logic [ROW_AW-1:0]     chk_row;
  logic                  chk_last;

  logic [ROW_BITS-1:0]   mem [MEM_DEPTH];
  logic [MEM_DEPTH-1:0]  row_valid;
  logic [ROW_BITS-1:0]   rd_data;
  logic                  rd_vld;

  logic                  mem_re;
  logic                  mem_we;
  logic [MEM_AW-1:0]     rd_addr;
  logic [MEM_AW-1:0]     wr_addr;
  logic [ROW_BITS-1:0]   rd_word;
  logic [ROW_BITS-1:0]   bit_mask;
  logic [ROW_BITS-1:0]   wr_data;
  logic [ROW_BITS-1:0]   cand;
  logic                  hit;
  logic [POS_W-1:0]      hit_pos;
  logic                  in_range;

  function automatic logic [POS_W-1:0] lowest_one(input logic [ROW_BITS-1:0] v);
    logic [POS_W-1:0] pos;
    pos = '0;
    for (int i = ROW_BITS - 1; i >= 0; i--) begin
      if (v[i]) begin
        pos = POS_W'(i);
      end
    end
    return pos;
  endfunction

  assign busy     = (state != S_IDLE);
  assign in_range = (16'(bit_index) < 16'(MAP_BITS));

  assign mem_re  = (state == S_RMW_RD) || ((state == S_SCAN) && issuing);
  assign rd_addr = (state == S_RMW_RD) ? {op_map, op_row} : {op_map, iss_row};
  assign mem_we  = (state == S_RMW_WR);
  assign wr_addr = {op_map, op_row};

  // Rows never written since reset read as all zeros.
  assign rd_word  = rd_vld ? rd_data : '0;
  assign bit_mask = ROW_BITS'(1) << op_pos;
  assign wr_data  = op_set ? (rd_word | bit_mask) : (rd_word & ~bit_mask);

  // Bits past the scan limit in the last row count as taken.
  assign cand    = ~rd_word & (chk_last ? LAST_MASK : '1);
  assign hit     = |cand;
  assign hit_pos = lowest_one(cand);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    if (mem_re) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      rd_vld    <= 1'b0;
    end else begin
      if (mem_we) begin
        row_valid[wr_addr] <= 1'b1;
      end
      if (mem_re) begin
        rd_vld <= row_valid[rd_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      done       <= 1'b0;
      found      <= 1'b0;
      free_index <= '0;
      issuing    <= 1'b0;
      chk_vld    <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            op_set <= (command == CMD_SET);
            op_map <= map_select;
            op_row <= ROW_AW'(bit_index >> POS_W);
            op_pos <= bit_index[POS_W-1:0];
            if (command == CMD_FIND) begin
              iss_row <= '0;
              issuing <= 1'b1;
              chk_vld <= 1'b0;
              done    <= 1'b0;
              state   <= S_SCAN;
            end else if ((command == CMD_SET || command == CMD_CLEAR) && in_range) begin
              done  <= 1'b0;
              state <= S_RMW_RD;
            end else begin
              // Unused commands and out-of-range indexes change nothing.
              done       <= 1'b1;
              found      <= 1'b0;
              free_index <= '0;
            end
          end else begin
            done <= 1'b0;
          end
        end
        S_RMW_RD: begin
          done  <= 1'b0;
          state <= S_RMW_WR;
        end
        S_RMW_WR: begin
          done       <= 1'b1;
          found      <= 1'b0;
          free_index <= '0;
          state      <= S_IDLE;
        end
        S_SCAN: begin
          if (chk_vld && (hit || chk_last)) begin
            done       <= 1'b1;
            found      <= hit;
            free_index <= hit ? IDX_W'({chk_row, hit_pos}) : '0;
            issuing    <= 1'b0;
            chk_vld    <= 1'b0;
            state      <= S_IDLE;
          end else begin
            // Reads are issued one row ahead of the check of the row read before.
            done     <= 1'b0;
            chk_vld  <= issuing;
            chk_row  <= iss_row;
            chk_last <= (iss_row == LAST_ROW);
            if (issuing) begin
              if (iss_row == LAST_ROW) begin
                issuing <= 1'b0;
              end else begin
                iss_row <= iss_row + ROW_AW'(1);
              end
            end
          end
        end
        default: begin
          done  <= 1'b0;
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: sv/dba_checker.sv
// Port-level checker for the dual bitmap allocator and its bind to the top level.
`default_nettype none

module dba_checker (
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      start,
  input wire logic                      busy,
  input wire logic [dba_pkg::CMD_W-1:0] command,
  input wire logic                      done,
  input wire logic [dba_pkg::IDX_W-1:0] free_index,
  input wire logic                      found
);
  import dba_pkg::*;

  // A result is shown only when no transaction is still in progress.
  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result shown while busy");

  // Every accepted transaction either shows its result next or keeps the block busy.
  assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> (busy || done))
    else $error("accepted transaction neither busy nor done");

  // A result only follows an accepted transaction or a busy period.
  assert property (@(posedge clk) disable iff (rst)
      done |-> ($past(start && !busy) || $past(busy)))
    else $error("result without a transaction");

  // A miss or a set/clear result carries a zero index.
  assert property (@(posedge clk) disable iff (rst) (done && !found) |-> (free_index == '0))
    else $error("nonzero index without a find hit");

  // No hit is reported right after a non-find command is taken.
  assert property (@(posedge clk) disable iff (rst)
      (start && !busy && command != CMD_FIND) |=> !(done && found))
    else $error("hit reported for a non-find command");

endmodule

bind dual_bitmap_allocator dba_checker u_dba_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .command    (command),
  .done       (done),
  .free_index (free_index),
  .found      (found)
);

`default_nettype wire

FILE: tb/sv/tb_dual_bitmap_allocator.sv
// Self-checking testbench for the dual bitmap allocator: set, clear and find-first-free commands.
module tb_dual_bitmap_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  import dba_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam logic MAP_INODE = 1'b0;
  localparam logic MAP_BLOCK = 1'b1;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int DRAIN_CYCLES  = 80;
  localparam int RANDOM_PER_PHASE = 100;
  localparam int FILL_BITS     = 128;
  localparam int MAX_PRINTED   = 100;

  typedef struct packed {
    logic [IDX_W-1:0] free_index;
    logic             found;
  } alloc_result_t;

  // Tracks both bitmaps and the results that accepted commands still owe.
  class alloc_scoreboard;
    logic [7:0]    maps [2][MAP_BYTES];
    alloc_result_t owed_q[$];
    int            errors;
    int            commands;
    int            results;
    int            finds_hit;
    int            finds_full;

    function new();
      for (int m = 0; m < 2; m++)
        for (int b = 0; b < MAP_BYTES; b++)
          maps[m][b] = 8'h00;
      errors = 0;
      commands = 0;
      results = 0;
      finds_hit = 0;
      finds_full = 0;
    endfunction

    // Lowest zero bit of a map, or -1 when every scanned bit is set.
    function int first_free(logic sel);
      for (int n = 0; n < SCAN_BITS; n++)
        if (maps[sel][n >> 3][7 - (n % 8)] == 1'b0) return n;
      return -1;
    endfunction

    function int owed();
      return owed_q.size();
    endfunction

    task report_mismatch(string what);
      errors++;
      if (errors <= MAX_PRINTED)
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    function void note_command(logic [CMD_W-1:0] cmd, logic sel, logic [IDX_W-1:0] idx);
      alloc_result_t r;
      int byte_no;
      int ff;
      r = '0;
      byte_no = idx >> 3;
      commands++;
      case (cmd)
        CMD_SET: begin
          if (byte_no < MAP_BYTES) maps[sel][byte_no][7 - idx[2:0]] = 1'b1;
        end
        CMD_CLEAR: begin
          if (byte_no < MAP_BYTES) maps[sel][byte_no][7 - idx[2:0]] = 1'b0;
        end
        CMD_FIND: begin
          ff = first_free(sel);
          if (ff >= 0) begin
            r.free_index = IDX_W'(ff);
            r.found = 1'b1;
            finds_hit++;
          end else begin
            finds_full++;
          end
        end
        default: ;
      endcase
      owed_q.push_back(r);
    endfunction

    task check_result(logic [IDX_W-1:0] fi, logic fnd);
      alloc_result_t exp_r;
      results++;
      if (owed_q.size() == 0) begin
        report_mismatch($sformatf("result index %0d found %0d with no command pending",
                                  fi, fnd));
      end else begin
        exp_r = owed_q.pop_front();
        if (fi !== exp_r.free_index)
          report_mismatch($sformatf("free_index %0d, expected %0d", fi, exp_r.free_index));
        if (fnd !== exp_r.found)
          report_mismatch($sformatf("found %0d, expected %0d", fnd, exp_r.found));
      end
    endtask
  endclass

  logic             clk;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic [CMD_W-1:0] command = CMD_SET;
  logic             map_select = MAP_INODE;
  logic [IDX_W-1:0] bit_index = '0;
  logic             busy;
  logic             done;
  logic [IDX_W-1:0] free_index;
  logic             found;

  alloc_scoreboard sb = new();
  int idle_pct = 0;
  int cycles = 0;

  dual_bitmap_allocator i_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .command    (command),
    .map_select (map_select),
    .bit_index  (bit_index),
    .done       (done),
    .free_index (free_index),
    .found      (found)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && done) sb.check_result(free_index, found);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.", cycles, sb.owed());
      $display("FAILURE");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after the transaction is taken.
  task automatic send_command(logic [CMD_W-1:0] cmd, logic sel, logic [IDX_W-1:0] idx);
    logic taken;
    while ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    start = 1'b1;
    command = cmd;
    map_select = sel;
    bit_index = idx;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      taken = !busy;
    end
    sb.note_command(cmd, sel, idx);
    @(negedge clk);
  endtask

  // Mostly allocator traffic: finds, allocation of the first free bit and release of
  // bits known to be set; the remainder is unconstrained noise including the unused code.
  task automatic random_command();
    int pick;
    int ff;
    logic sel;
    pick = $urandom_range(99);
    sel = 1'($urandom_range(1));
    ff = sb.first_free(sel);
    if (pick < 40)
      send_command(CMD_FIND, sel, IDX_W'($urandom));
    else if (pick < 65)
      send_command(CMD_SET, sel, (ff >= 0) ? IDX_W'(ff) : IDX_W'($urandom));
    else if (pick < 85 && ff > 0)
      send_command(CMD_CLEAR, sel, IDX_W'($urandom_range(ff - 1)));
    else
      send_command(CMD_W'($urandom), sel, IDX_W'($urandom));
  endtask

  initial begin
    int ff;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    idle_pct = 27;
    // Empty maps, byte and row boundaries, repeated set and clear, the unused code.
    send_command(CMD_FIND, MAP_INODE, 12'hFFF);
    send_command(CMD_FIND, MAP_BLOCK, 12'h000);
    send_command(CMD_UNUSED, MAP_INODE, 12'hFFF);
    send_command(CMD_SET, MAP_INODE, 12'd0);
    send_command(CMD_FIND, MAP_INODE, 12'd0);
    send_command(CMD_SET, MAP_INODE, 12'd1);
    send_command(CMD_SET, MAP_INODE, 12'd7);
    send_command(CMD_SET, MAP_INODE, 12'd8);
    send_command(CMD_SET, MAP_INODE, 12'd4095);
    send_command(CMD_SET, MAP_INODE, 12'd63);
    send_command(CMD_SET, MAP_INODE, 12'd64);
    send_command(CMD_FIND, MAP_INODE, 12'd0);
    send_command(CMD_CLEAR, MAP_INODE, 12'd0);
    send_command(CMD_FIND, MAP_INODE, 12'd0);
    send_command(CMD_CLEAR, MAP_INODE, 12'd0);
    send_command(CMD_SET, MAP_INODE, 12'd0);
    send_command(CMD_SET, MAP_INODE, 12'd0);
    send_command(CMD_CLEAR, MAP_INODE, 12'd4095);
    send_command(CMD_UNUSED, MAP_BLOCK, 12'd0);
    send_command(CMD_SET, MAP_BLOCK, 12'd0);
    send_command(CMD_FIND, MAP_BLOCK, 12'd0);
    send_command(CMD_FIND, MAP_INODE, 12'd0);
    send_command(CMD_CLEAR, MAP_INODE, 12'd64);
    send_command(CMD_CLEAR, MAP_INODE, 12'd63);

    repeat (RANDOM_PER_PHASE) random_command();
    idle_pct = 59;
    repeat (RANDOM_PER_PHASE) random_command();
    idle_pct = 0;

    // Fill the low rows of the block map so that finds have to scan past two rows.
    for (int n = 0; n < FILL_BITS; n++) send_command(CMD_SET, MAP_BLOCK, IDX_W'(n));
    send_command(CMD_FIND, MAP_BLOCK, 12'd0);
    send_command(CMD_CLEAR, MAP_BLOCK, IDX_W'(FILL_BITS - 1));
    send_command(CMD_FIND, MAP_BLOCK, 12'd0);
    send_command(CMD_SET, MAP_BLOCK, IDX_W'(FILL_BITS - 1));
    repeat (20) begin
      send_command(CMD_CLEAR, MAP_BLOCK, IDX_W'($urandom));
      send_command(CMD_FIND, MAP_BLOCK, IDX_W'($urandom));
      ff = sb.first_free(MAP_BLOCK);
      if (ff >= 0) send_command(CMD_SET, MAP_BLOCK, IDX_W'(ff));
    end
    repeat (RANDOM_PER_PHASE) random_command();
    start = 1'b0;

    while (sb.owed() != 0) @(posedge clk);
    // Any stray result in this window is flagged by the monitor.
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d commands on both maps, with deep scans of a block map filled %0d bits.",
             sb.commands, FILL_BITS);
    $display("Checked %0d results; finds: %0d hit, %0d full map; %0d mismatches.",
             sb.results, sb.finds_hit, sb.finds_full, sb.errors);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
